// ----- hdl/psched_pkg.sv -----
// Shared definitions of the priority bitmap thread scheduler.
// Holds default parameter values, opcode and status codes and the sequencer states.
// No dependencies.
package psched_pkg;

	localparam int THREAD_COUNT_DEF = 32;
	localparam int TIMEOUT_BITS_DEF = 32;

	typedef enum logic [2:0] {
		OP_START    = 3'd0,
		OP_DELAY    = 3'd1,
		OP_TICK     = 3'd2,
		OP_SWITCH   = 3'd3,
		OP_SCHEDULE = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_START = 2'd1,
		ST_BAD_DELAY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_TICK,
		S_FIND,
		S_DONE
	} state_t;

endpackage

// ----- hdl/psched_ram.sv -----
// Timeout memory of the scheduler: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module psched_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/psched_find.sv -----
// Highest-set-bit search over the ready mask, registered result.
// Searches eight-bit groups first, then picks the highest non-empty group.
module psched_find #(
	parameter int THREAD_COUNT = 32,
	parameter int TW           = 6
) (
	input  logic                    clk,
	input  logic [THREAD_COUNT-1:0] mask,
	output logic [TW-1:0]           next
);

	localparam int GROUPS = (THREAD_COUNT + 7) / 8;
	localparam int PADW   = GROUPS * 8;

	logic [PADW-1:0]   pad;
	logic [GROUPS-1:0] grp_any;
	logic [2:0]        grp_pos [GROUPS];
	logic [TW-1:0]     best;
	logic [TW-1:0]     next_q;

	assign pad = PADW'(mask);

	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			grp_any[g] = |pad[g*8 +: 8];
			grp_pos[g] = 3'd0;
			for (int b = 0; b < 8; b++) begin
				if (pad[g*8 + b]) begin
					grp_pos[g] = 3'(b);
				end
			end
		end
	end

	// Priority p owns bit p-1, so the answer is the bit position plus one.
	always_comb begin
		best = '0;
		for (int g = 0; g < GROUPS; g++) begin
			if (grp_any[g]) begin
				best = TW'(g * 8 + int'(grp_pos[g]) + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		next_q <= best;
	end

	assign next = next_q;

endmodule

// ----- hdl/priority_bitmap_thread_scheduler.sv -----
// Top level of the priority bitmap thread scheduler.
// Depends on psched_pkg, psched_ram and psched_find.

// The scheduler takes one opcode beat at a time and returns one result beat for
// each: the highest ready priority (0 for the idle thread when nothing is
// ready), a switch request when that differs from the running thread or no
// thread runs yet, a status code and the ready and delayed masks. Start,
// delay, switch done and schedule pass from acceptance through S_FIND, where
// the registered priority search settles, to S_DONE, which loads the output
// register once it is free. A tick walks every timeout entry through the
// timeout memory and its registered read data, one entry per cycle with read
// and write-back overlapped, before it goes on to S_FIND and S_DONE. The
// next opcode is accepted as soon as the previous result is loaded, even if
// that result still waits at the output. Timeout entries are only acted on
// for delayed threads, whose entry a delay has written, so the memory needs
// no clearing after reset.
module priority_bitmap_thread_scheduler #(
	parameter int THREAD_COUNT = psched_pkg::THREAD_COUNT_DEF,
	parameter int TIMEOUT_BITS = psched_pkg::TIMEOUT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [5:0]  priority_req,
	input  logic [31:0] delay_ticks,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  next_thread,
	output logic        switch_needed,
	output logic [1:0]  status,
	output logic [31:0] ready_bits,
	output logic [31:0] delayed_bits
);

	import psched_pkg::*;

	// PW indexes a thread's mask bit and timeout entry; TW holds 0..THREAD_COUNT.
	localparam int PW = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
	localparam int TW = $clog2(THREAD_COUNT + 1);

	state_t state_q, state_d;

	logic [THREAD_COUNT-1:0] ready_q;
	logic [THREAD_COUNT-1:0] delayed_q;
	logic [THREAD_COUNT:0]   occ_q;
	logic [TW-1:0]           current_q;
	logic                    current_valid_q;
	logic [TW-1:0]           chosen_q;
	status_t                 status_q;

	// Walk of the timeout memory during a tick.
	logic          rd_act_q;
	logic [PW-1:0] rd_idx_q;
	logic          act_s1;
	logic [PW-1:0] idx_s1;

	// Output register.
	logic          out_valid_q;
	logic [5:0]    next_thread_q;
	logic          switch_q;
	logic [1:0]    status_out_q;
	logic [31:0]   ready_out_q;
	logic [31:0]   delayed_out_q;

	logic                    accept;
	logic                    is_start, is_delay, is_tick, is_switch;
	logic [TIMEOUT_BITS-1:0] ticks_m;
	logic                    start_bad;
	logic                    delay_ok;
	logic [TW-1:0]           occ_idx;
	logic [PW-1:0]           prio_bit;
	logic [PW-1:0]           cur_bit;
	logic                    walk_last;
	logic                    tick_hit;
	logic                    tick_expire;
	logic                    load_out;

	logic                    ram_we;
	logic [PW-1:0]           ram_waddr;
	logic [TIMEOUT_BITS-1:0] ram_wdata;
	logic [TIMEOUT_BITS-1:0] ram_rdata;
	logic [TW-1:0]           found;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	assign is_start  = (opcode == OP_START);
	assign is_delay  = (opcode == OP_DELAY);
	assign is_tick   = (opcode == OP_TICK);
	assign is_switch = (opcode == OP_SWITCH);

	assign ticks_m  = TIMEOUT_BITS'(delay_ticks);
	assign occ_idx  = TW'(priority_req);
	assign prio_bit = PW'(priority_req - 6'd1);
	assign cur_bit  = PW'(current_q - TW'(1));

	// Out-of-range priorities are rejected before the occupied slot matters.
	assign start_bad = (7'(priority_req) > 7'(THREAD_COUNT)) || occ_q[occ_idx];
	assign delay_ok  = current_valid_q && (current_q != '0) && (ticks_m != '0);

	// The walk retires entry idx_s1 in the cycle after its read was issued.
	assign tick_hit    = act_s1 && delayed_q[idx_s1];
	assign tick_expire = (ram_rdata <= TIMEOUT_BITS'(1));
	assign walk_last   = act_s1 && !rd_act_q;

	// A delay writes at acceptance and the walk writes only in S_TICK, so the
	// two writers never meet; read and write-back of the walk are one entry apart.
	always_comb begin
		if (tick_hit) begin
			ram_we    = 1'b1;
			ram_waddr = idx_s1;
			ram_wdata = tick_expire ? '0 : ram_rdata - TIMEOUT_BITS'(1);
		end else begin
			ram_we    = accept && is_delay && delay_ok;
			ram_waddr = cur_bit;
			ram_wdata = ticks_m;
		end
	end

	psched_ram #(
		.DEPTH(THREAD_COUNT),
		.WIDTH(TIMEOUT_BITS),
		.AW   (PW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

	psched_find #(
		.THREAD_COUNT(THREAD_COUNT),
		.TW          (TW)
	) u_find (
		.clk (clk),
		.mask(ready_q),
		.next(found)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = is_tick ? S_TICK : S_FIND;
				end
			end
			S_TICK: begin
				if (walk_last) begin
					state_d = S_FIND;
				end
			end
			S_FIND: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				// The finished result waits here until the output register is free.
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Scheduler state and the walk counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q         <= '0;
			delayed_q       <= '0;
			occ_q           <= '0;
			current_q       <= '0;
			current_valid_q <= 1'b0;
			chosen_q        <= '0;
			status_q        <= ST_OK;
			rd_act_q        <= 1'b0;
			rd_idx_q        <= '0;
			act_s1          <= 1'b0;
			idx_s1          <= '0;
		end else begin
			act_s1 <= rd_act_q;
			idx_s1 <= rd_idx_q;
			if (rd_act_q) begin
				if (rd_idx_q == PW'(THREAD_COUNT - 1)) begin
					rd_act_q <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + PW'(1);
				end
			end
			if (tick_hit && tick_expire) begin
				ready_q[idx_s1]   <= 1'b1;
				delayed_q[idx_s1] <= 1'b0;
			end
			if (accept) begin
				unique case (1'b1)
					is_start: begin
						if (start_bad) begin
							status_q <= ST_BAD_START;
						end else begin
							status_q       <= ST_OK;
							occ_q[occ_idx] <= 1'b1;
							if (priority_req != 6'd0) begin
								ready_q[prio_bit] <= 1'b1;
							end
						end
					end
					is_delay: begin
						if (!delay_ok) begin
							status_q <= ST_BAD_DELAY;
						end else begin
							status_q           <= ST_OK;
							ready_q[cur_bit]   <= 1'b0;
							delayed_q[cur_bit] <= 1'b1;
						end
					end
					is_tick: begin
						status_q <= ST_OK;
						rd_act_q <= 1'b1;
						rd_idx_q <= '0;
					end
					is_switch: begin
						status_q        <= ST_OK;
						current_q       <= chosen_q;
						current_valid_q <= 1'b1;
					end
					default: begin
						status_q <= ST_OK;
					end
				endcase
			end
			if (load_out) begin
				chosen_q <= found;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			next_thread_q <= 6'(found);
			switch_q      <= !current_valid_q || (found != current_q);
			status_out_q  <= status_q;
			ready_out_q   <= 32'(ready_q);
			delayed_out_q <= 32'(delayed_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign next_thread   = next_thread_q;
	assign switch_needed = switch_q;
	assign status        = status_out_q;
	assign ready_bits    = ready_out_q;
	assign delayed_bits  = delayed_out_q;

	// A thread is never ready and delayed at once.
	a_masks_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		(ready_q & delayed_q) == '0)
		else $error("thread both ready and delayed");

	// Every thread in a mask has an occupied slot.
	a_masks_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		((ready_q | delayed_q) & ~occ_q[THREAD_COUNT:1]) == '0)
		else $error("mask bit without occupied slot");

	// The timeout walk runs only while a tick is in progress.
	a_walk_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_act_q || act_s1) |-> (state_q == S_TICK))
		else $error("timeout walk outside a tick");

	// A new result appears only when the sequencer finishes an item.
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result loaded outside completion");

endmodule
